[src/assert_macros.svh]
// Assertion macros shared by the timer table RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Property checked at every rising clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Implication checked at every rising clock edge outside reset.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst_n, prop, msg)
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

[src/tmr_pkg.sv]
// Shared types and constants of the timer table.
package tmr_pkg;

    localparam int ID_W   = 32;
    localparam int AMT_W  = 32;
    localparam int KIND_W = 3;

    // Requested operation of an input item.
    typedef enum logic [1:0] {
        ACT_REG_PER = 2'd0,
        ACT_REG_ONE = 2'd1,
        ACT_CANCEL  = 2'd2,
        ACT_TICK    = 2'd3
    } t_action;

    // Kind of a result item.
    typedef enum logic [KIND_W-1:0] {
        KIND_REGISTERED = 3'd0,
        KIND_FIRED      = 3'd1,
        KIND_CANCELLED  = 3'd2,
        KIND_DONE       = 3'd3,
        KIND_ZERO_DELAY = 3'd4,
        KIND_FULL       = 3'd5
    } t_kind;

    // Status of the entry at the head of the ring.
    typedef struct packed {
        logic fire;
        logic take;
    } t_head_ctl;

endpackage

[src/tmr_cell.sv]
// One slot of the timer ring; loads its neighbor's entry on every shift.
module tmr_cell #(
    parameter int TIME_WIDTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_shift,
    input  logic                     i_valid,
    input  logic [tmr_pkg::ID_W-1:0] i_ident,
    input  logic [TIME_WIDTH-1:0]    i_period,
    input  logic [TIME_WIDTH-1:0]    i_remaining,
    output logic                     o_valid,
    output logic [tmr_pkg::ID_W-1:0] o_ident,
    output logic [TIME_WIDTH-1:0]    o_period,
    output logic [TIME_WIDTH-1:0]    o_remaining
);

    logic                     r_valid;
    logic [tmr_pkg::ID_W-1:0] r_ident;
    logic [TIME_WIDTH-1:0]    r_period;
    logic [TIME_WIDTH-1:0]    r_remaining;

    // The live flag is cleared by reset; an empty slot is never read.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_shift) begin
            r_valid <= i_valid;
        end
    end

    // Timer payload moves along with the live flag.
    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_ident     <= i_ident;
            r_period    <= i_period;
            r_remaining <= i_remaining;
        end
    end

    assign o_valid     = r_valid;
    assign o_ident     = r_ident;
    assign o_period    = r_period;
    assign o_remaining = r_remaining;

endmodule

[src/tmr_head.sv]
// Applies the current operation to the entry at the head of the ring.
module tmr_head #(
    parameter int TIME_WIDTH = 32
) (
    input  tmr_pkg::t_action         i_action,
    input  logic [TIME_WIDTH-1:0]    i_amount,
    input  logic [tmr_pkg::ID_W-1:0] i_timer_id,
    input  logic [tmr_pkg::ID_W-1:0] i_new_ident,
    input  logic                     i_placed,
    input  logic                     i_valid,
    input  logic [tmr_pkg::ID_W-1:0] i_ident,
    input  logic [TIME_WIDTH-1:0]    i_period,
    input  logic [TIME_WIDTH-1:0]    i_remaining,
    output logic                     o_valid,
    output logic [tmr_pkg::ID_W-1:0] o_ident,
    output logic [TIME_WIDTH-1:0]    o_period,
    output logic [TIME_WIDTH-1:0]    o_remaining,
    output tmr_pkg::t_head_ctl       o_ctl
);

    // By default the entry passes unchanged to the tail of the ring.
    always_comb begin
        o_valid     = i_valid;
        o_ident     = i_ident;
        o_period    = i_period;
        o_remaining = i_remaining;
        o_ctl       = '0;
        case (i_action)
            tmr_pkg::ACT_REG_PER, tmr_pkg::ACT_REG_ONE: begin
                // The first empty slot seen in the walk is the lowest one.
                if (!i_valid && !i_placed) begin
                    o_valid     = 1'b1;
                    o_ident     = i_new_ident;
                    o_period    = (i_action == tmr_pkg::ACT_REG_PER) ? i_amount : '0;
                    o_remaining = i_amount;
                    o_ctl.take  = 1'b1;
                end
            end
            tmr_pkg::ACT_CANCEL: begin
                if (i_valid && (i_ident == i_timer_id)) begin
                    o_valid = 1'b0;
                end
            end
            tmr_pkg::ACT_TICK: begin
                // Expiry reloads a periodic timer and frees a one-shot timer.
                if (i_valid) begin
                    if (i_amount >= i_remaining) begin
                        o_ctl.fire = 1'b1;
                        if (i_period != '0) begin
                            o_remaining = i_period;
                        end else begin
                            o_valid = 1'b0;
                        end
                    end else begin
                        o_remaining = i_remaining - i_amount;
                    end
                end
            end
            default: begin
            end
        endcase
    end

endmodule

[src/periodic_oneshot_timer_table.sv]
// Top level of the timer table: ring of slot cells, head logic and control.
//
// Input channel (i_valid, o_stall) carries one request item: register a
// periodic or one-shot timer, cancel an identifier, or tick by an elapsed
// count. Output channel (o_valid, i_stall) returns the result items.
// Each slot lives in a cell of a ring. A request rotates the whole ring once,
// one slot per cycle through the head logic unless the walk pauses for a
// stalled output; a closing state then emits the closing result. A register
// with zero delay skips the walk and goes straight to the closing state. The
// block takes the next request once it is back in idle. Results are held in
// the output register until the receiver takes them. A tick emits one fired
// item per expiring slot in slot order, then the done item with o_last set;
// every other request gives a single item with o_last set.
// While the receiver stalls, the output register holds its item and the walk
// pauses at any slot that must emit. Reset empties every slot, sets the next
// identifier to 1 and leaves the block idle with no result pending.
`include "assert_macros.svh"

module periodic_oneshot_timer_table #(
    parameter int NUM_TIMERS = 16,
    parameter int TIME_WIDTH = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [1:0]                   i_action,
    input  logic [tmr_pkg::AMT_W-1:0]    i_amount_ms,
    input  logic [tmr_pkg::ID_W-1:0]     i_timer_id,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [tmr_pkg::KIND_W-1:0]   o_kind,
    output logic [tmr_pkg::ID_W-1:0]     o_result_id,
    output logic                         o_last
);

    localparam int SW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_FINISH
    } t_state;

    t_state                     r_state;
    logic [SW-1:0]              r_step;
    tmr_pkg::t_action           r_action;
    logic [TIME_WIDTH-1:0]      r_amount;
    logic [tmr_pkg::ID_W-1:0]   r_timer_id;
    logic [tmr_pkg::ID_W-1:0]   r_next_id;
    logic [tmr_pkg::ID_W-1:0]   r_reg_id;
    logic                       r_placed;
    logic                       r_zero;
    logic                       r_out_valid;
    tmr_pkg::t_kind             r_kind;
    logic [tmr_pkg::ID_W-1:0]   r_result_id;
    logic                       r_last;

    logic [TIME_WIDTH+tmr_pkg::AMT_W-1:0] amt_wide;
    logic [TIME_WIDTH-1:0]      amt_sat;
    logic [tmr_pkg::ID_W-1:0]   n_next_id;
    logic                       out_free;
    logic                       out_load;
    logic                       shift;
    logic                       is_reg;
    tmr_pkg::t_kind             final_kind;
    logic [tmr_pkg::ID_W-1:0]   final_id;

    logic                       c_valid     [NUM_TIMERS];
    logic [tmr_pkg::ID_W-1:0]   c_ident     [NUM_TIMERS];
    logic [TIME_WIDTH-1:0]      c_period    [NUM_TIMERS];
    logic [TIME_WIDTH-1:0]      c_remaining [NUM_TIMERS];

    logic                       h_valid;
    logic [tmr_pkg::ID_W-1:0]   h_ident;
    logic [TIME_WIDTH-1:0]      h_period;
    logic [TIME_WIDTH-1:0]      h_remaining;
    tmr_pkg::t_head_ctl         h_ctl;

    // Clamp the request amount to the time width.
    always_comb begin
        amt_wide = {{TIME_WIDTH{1'b0}}, i_amount_ms};
        amt_sat  = (|(amt_wide >> TIME_WIDTH)) ? '1 : amt_wide[TIME_WIDTH-1:0];
        is_reg   = (tmr_pkg::t_action'(i_action) == tmr_pkg::ACT_REG_PER) ||
                   (tmr_pkg::t_action'(i_action) == tmr_pkg::ACT_REG_ONE);
    end

    // Identifier counter skips zero on wrap.
    assign n_next_id = ((r_next_id + 1'b1) == '0) ? tmr_pkg::ID_W'(1) : (r_next_id + 1'b1);

    // The output register can take a new item this cycle.
    assign out_free = !r_out_valid || !i_stall;

    // The ring advances unless the head must emit into a full output register.
    assign shift = (r_state == ST_WALK) && (!h_ctl.fire || out_free);

    // A new item enters the output register this cycle.
    assign out_load = (shift && h_ctl.fire) || ((r_state == ST_FINISH) && out_free);

    // Closing result of the current request.
    always_comb begin
        final_kind = tmr_pkg::KIND_DONE;
        final_id   = '0;
        case (r_action)
            tmr_pkg::ACT_REG_PER, tmr_pkg::ACT_REG_ONE: begin
                if (r_zero) begin
                    final_kind = tmr_pkg::KIND_ZERO_DELAY;
                end else if (r_placed) begin
                    final_kind = tmr_pkg::KIND_REGISTERED;
                    final_id   = r_reg_id;
                end else begin
                    final_kind = tmr_pkg::KIND_FULL;
                end
            end
            tmr_pkg::ACT_CANCEL: begin
                final_kind = tmr_pkg::KIND_CANCELLED;
            end
            default: begin
                final_kind = tmr_pkg::KIND_DONE;
            end
        endcase
    end

    // Head logic works on the slot currently in cell zero.
    tmr_head #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_head (
        .i_action    (r_action),
        .i_amount    (r_amount),
        .i_timer_id  (r_timer_id),
        .i_new_ident (r_next_id),
        .i_placed    (r_placed),
        .i_valid     (c_valid[0]),
        .i_ident     (c_ident[0]),
        .i_period    (c_period[0]),
        .i_remaining (c_remaining[0]),
        .o_valid     (h_valid),
        .o_ident     (h_ident),
        .o_period    (h_period),
        .o_remaining (h_remaining),
        .o_ctl       (h_ctl)
    );

    // Ring of cells: each takes its upper neighbor, the last takes the head.
    for (genvar g = 0; g < NUM_TIMERS; g++) begin : g_cell
        if (g == NUM_TIMERS - 1) begin : g_tail
            tmr_cell #(
                .TIME_WIDTH (TIME_WIDTH)
            ) u_cell (
                .i_clk       (i_clk),
                .i_rst_n     (i_rst_n),
                .i_shift     (shift),
                .i_valid     (h_valid),
                .i_ident     (h_ident),
                .i_period    (h_period),
                .i_remaining (h_remaining),
                .o_valid     (c_valid[g]),
                .o_ident     (c_ident[g]),
                .o_period    (c_period[g]),
                .o_remaining (c_remaining[g])
            );
        end else begin : g_mid
            tmr_cell #(
                .TIME_WIDTH (TIME_WIDTH)
            ) u_cell (
                .i_clk       (i_clk),
                .i_rst_n     (i_rst_n),
                .i_shift     (shift),
                .i_valid     (c_valid[g+1]),
                .i_ident     (c_ident[g+1]),
                .i_period    (c_period[g+1]),
                .i_remaining (c_remaining[g+1]),
                .o_valid     (c_valid[g]),
                .o_ident     (c_ident[g]),
                .o_period    (c_period[g]),
                .o_remaining (c_remaining[g])
            );
        end
    end

    // Controller: request capture, walk sequencing and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_step      <= '0;
            r_next_id   <= tmr_pkg::ID_W'(1);
            r_placed    <= 1'b0;
            r_zero      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (!i_stall && !out_load) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (i_valid) begin
                        r_action   <= tmr_pkg::t_action'(i_action);
                        r_amount   <= amt_sat;
                        r_timer_id <= i_timer_id;
                        r_placed   <= 1'b0;
                        r_zero     <= is_reg && (amt_sat == '0);
                        r_state    <= (is_reg && (amt_sat == '0)) ? ST_FINISH : ST_WALK;
                    end
                end
                ST_WALK: begin
                    if (shift) begin
                        if (h_ctl.take) begin
                            r_placed  <= 1'b1;
                            r_reg_id  <= r_next_id;
                            r_next_id <= n_next_id;
                        end
                        if (h_ctl.fire) begin
                            r_out_valid <= 1'b1;
                            r_kind      <= tmr_pkg::KIND_FIRED;
                            r_result_id <= c_ident[0];
                            r_last      <= 1'b0;
                        end
                        if (r_step == SW'(NUM_TIMERS - 1)) begin
                            r_step  <= '0;
                            r_state <= ST_FINISH;
                        end else begin
                            r_step <= r_step + 1'b1;
                        end
                    end
                end
                ST_FINISH: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_kind      <= final_kind;
                        r_result_id <= final_id;
                        r_last      <= 1'b1;
                        r_state     <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_stall     = (r_state != ST_IDLE);
    assign o_valid     = r_out_valid;
    assign o_kind      = r_kind;
    assign o_result_id = r_result_id;
    assign o_last      = r_last;

    // Checks on the controller.
    `ASSERT_IMPLY(a_step_idle, i_clk, i_rst_n, r_state != ST_WALK, r_step == '0, "step count outside walk")
    `ASSERT_CLK(a_id_nonzero, i_clk, i_rst_n, r_next_id != '0, "next identifier is zero")
    `ASSERT_IMPLY(a_fired_not_last, i_clk, i_rst_n, o_valid && (o_kind == tmr_pkg::KIND_FIRED), !o_last, "fired item marked last")
    `ASSERT_NEXT(a_finish_emits, i_clk, i_rst_n, (r_state == ST_FINISH) && out_free, (r_state == ST_IDLE) && o_valid && o_last, "closing item not emitted")

endmodule

[verif/timer_table_checker.sv]
`timescale 1ns / 100ps
// Checker for the timer table: predicts result items and compares them as they leave.
module timer_table_checker #(
    parameter int NUM_SLOTS = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_req_valid,
    input  logic                            i_req_stall,
    input  logic [1:0]                      i_action,
    input  logic [tmr_pkg::AMT_W-1:0]       i_amount_ms,
    input  logic [tmr_pkg::ID_W-1:0]        i_timer_id,
    input  logic                            i_res_valid,
    input  logic                            i_res_stall,
    input  logic [tmr_pkg::KIND_W-1:0]      i_kind,
    input  logic [tmr_pkg::ID_W-1:0]        i_result_id,
    input  logic                            i_last,
    output int                              o_fail_count,
    output int                              o_pending,
    output int                              o_result_count,
    output int                              o_fire_count
);

    localparam int REPORT_LIMIT = 10;

    // One result item as the table should produce it.
    typedef struct {
        tmr_pkg::t_kind            kind;
        logic [tmr_pkg::ID_W-1:0]  ident;
        logic                      last;
    } t_timer_result;

    // Shadow copy of the timer slots.
    logic                       slot_live [NUM_SLOTS];
    logic [tmr_pkg::ID_W-1:0]   slot_ident [NUM_SLOTS];
    logic [tmr_pkg::AMT_W-1:0]  slot_interval [NUM_SLOTS];
    logic [tmr_pkg::AMT_W-1:0]  slot_left [NUM_SLOTS];
    logic [tmr_pkg::ID_W-1:0]   next_timer_id;

    t_timer_result     pending_results [$];

    // Queue one expected result item.
    function automatic void push_result(tmr_pkg::t_kind kind, logic [tmr_pkg::ID_W-1:0] ident,
                                        logic last);
        t_timer_result item;
        item.kind  = kind;
        item.ident = ident;
        item.last  = last;
        pending_results.push_back(item);
    endfunction

    // Apply one request to the shadow table and queue the result items it causes.
    // Amounts are as wide as the table's time, so no saturation takes place.
    function automatic void apply_request(tmr_pkg::t_action act,
                                          logic [tmr_pkg::AMT_W-1:0] amount,
                                          logic [tmr_pkg::ID_W-1:0] ident);
        int free_slot;
        int s;
        free_slot = -1;
        case (act)
            tmr_pkg::ACT_REG_PER, tmr_pkg::ACT_REG_ONE: begin
                if (amount == '0) begin
                    push_result(tmr_pkg::KIND_ZERO_DELAY, '0, 1'b1);
                end else begin
                    for (s = 0; s < NUM_SLOTS; s++) begin
                        if (!slot_live[s] && free_slot < 0) free_slot = s;
                    end
                    if (free_slot < 0) begin
                        push_result(tmr_pkg::KIND_FULL, '0, 1'b1);
                    end else begin
                        slot_live[free_slot]     = 1'b1;
                        slot_ident[free_slot]    = next_timer_id;
                        slot_interval[free_slot] = (act == tmr_pkg::ACT_REG_PER) ? amount : '0;
                        slot_left[free_slot]     = amount;
                        push_result(tmr_pkg::KIND_REGISTERED, next_timer_id, 1'b1);
                        // The identifier skips zero when it wraps.
                        next_timer_id = next_timer_id + 1'b1;
                        if (next_timer_id == '0) next_timer_id = tmr_pkg::ID_W'(1);
                    end
                end
            end
            tmr_pkg::ACT_CANCEL: begin
                for (s = 0; s < NUM_SLOTS; s++) begin
                    if (slot_live[s] && slot_ident[s] == ident) slot_live[s] = 1'b0;
                end
                push_result(tmr_pkg::KIND_CANCELLED, '0, 1'b1);
            end
            default: begin
                // Tick: walk the slots in order; expired timers reload or leave.
                for (s = 0; s < NUM_SLOTS; s++) begin
                    if (slot_live[s]) begin
                        if (amount >= slot_left[s]) begin
                            if (slot_interval[s] != '0) slot_left[s] = slot_interval[s];
                            else slot_live[s] = 1'b0;
                            push_result(tmr_pkg::KIND_FIRED, slot_ident[s], 1'b0);
                        end else begin
                            slot_left[s] = slot_left[s] - amount;
                        end
                    end
                end
                push_result(tmr_pkg::KIND_DONE, '0, 1'b1);
            end
        endcase
    endfunction

    // Count a failure and describe the first few of them.
    function automatic void report_mismatch(string what, t_timer_result want);
        o_fail_count++;
        if (o_fail_count <= REPORT_LIMIT) begin
            $display("%0t: %s: expected kind %0d id %h last %0d, got kind %0d id %h last %0d",
                     $realtime, what, want.kind, want.ident, want.last,
                     i_kind, i_result_id, i_last);
        end
    endfunction

    // Predict on each accepted request, compare on each accepted result.
    always @(posedge i_clk) begin
        t_timer_result want;
        if (!i_rst_n) begin
            for (int s = 0; s < NUM_SLOTS; s++) begin
                slot_live[s] = 1'b0;
            end
            next_timer_id = tmr_pkg::ID_W'(1);
            pending_results.delete();
            o_fail_count   = 0;
            o_result_count = 0;
            o_fire_count   = 0;
        end else begin
            if (i_req_valid && !i_req_stall) begin
                apply_request(tmr_pkg::t_action'(i_action), i_amount_ms, i_timer_id);
            end
            if (i_res_valid && !i_res_stall) begin
                o_result_count++;
                if (pending_results.size() == 0) begin
                    want.kind  = tmr_pkg::KIND_DONE;
                    want.ident = '0;
                    want.last  = 1'b0;
                    report_mismatch("result with nothing expected", want);
                end else begin
                    want = pending_results.pop_front();
                    if (want.kind == tmr_pkg::KIND_FIRED) o_fire_count++;
                    if (i_kind !== want.kind || i_result_id !== want.ident ||
                        i_last !== want.last) begin
                        report_mismatch("result mismatch", want);
                    end
                end
            end
        end
        o_pending = pending_results.size();
    end

endmodule

[verif/tb_top.sv]
`timescale 1ns / 100ps
// Testbench top for the timer table: request stimulus, result stalls and the verdict.
module tb_top;

    localparam int NUM_TIMERS   = 16;
    localparam int RANDOM_ITEMS = 200;
    localparam int QUIET_ITEMS  = 40;

    bit                           clk;
    logic                         rst_n;
    logic                         req_valid;
    logic                         req_stall;
    logic [1:0]                   req_action;
    logic [tmr_pkg::AMT_W-1:0]    req_amount_ms;
    logic [tmr_pkg::ID_W-1:0]     req_timer_id;
    logic                         res_valid;
    logic                         res_stall;
    logic [tmr_pkg::KIND_W-1:0]   res_kind;
    logic [tmr_pkg::ID_W-1:0]     res_result_id;
    logic                         res_last;

    int                  fail_count;
    int                  pending_count;
    int                  result_count;
    int                  fire_count;

    // Idling is allowed on both sides while this is set.
    logic                idling_on;
    int                  stall_left;
    int                  ids_handed_out;
    int                  action_count [4];

    periodic_oneshot_timer_table #(
        .NUM_TIMERS (NUM_TIMERS)
    ) dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_valid     (req_valid),
        .o_stall     (req_stall),
        .i_action    (req_action),
        .i_amount_ms (req_amount_ms),
        .i_timer_id  (req_timer_id),
        .o_valid     (res_valid),
        .i_stall     (res_stall),
        .o_kind      (res_kind),
        .o_result_id (res_result_id),
        .o_last      (res_last)
    );

    timer_table_checker #(
        .NUM_SLOTS (NUM_TIMERS)
    ) result_check (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_req_valid    (req_valid),
        .i_req_stall    (req_stall),
        .i_action       (req_action),
        .i_amount_ms    (req_amount_ms),
        .i_timer_id     (req_timer_id),
        .i_res_valid    (res_valid),
        .i_res_stall    (res_stall),
        .i_kind         (res_kind),
        .i_result_id    (res_result_id),
        .i_last         (res_last),
        .o_fail_count   (fail_count),
        .o_pending      (pending_count),
        .o_result_count (result_count),
        .o_fire_count   (fire_count)
    );

    // Clock with a 10 ns period.
    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Receiver stalls in random bursts of random length.
    always @(negedge clk) begin
        if (!rst_n) begin
            res_stall  <= 1'b0;
            stall_left <= 0;
        end else if (stall_left != 0) begin
            res_stall  <= 1'b1;
            stall_left <= stall_left - 1;
        end else if (idling_on && $urandom_range(0, 4) == 0) begin
            res_stall  <= 1'b1;
            stall_left <= $urandom_range(0, 7);
        end else begin
            res_stall  <= 1'b0;
        end
    end

    // Present one request item and hold it until the table takes it.
    task automatic send_request(tmr_pkg::t_action act, logic [tmr_pkg::AMT_W-1:0] amount,
                                logic [tmr_pkg::ID_W-1:0] ident);
        @(negedge clk);
        req_valid     <= 1'b1;
        req_action    <= act;
        req_amount_ms <= amount;
        req_timer_id  <= ident;
        action_count[act]++;
        if ((act == tmr_pkg::ACT_REG_PER || act == tmr_pkg::ACT_REG_ONE) && amount != '0)
            ids_handed_out++;
        @(posedge clk);
        while (req_stall) @(posedge clk);
    endtask

    // Sender gap of random length, now and then.
    task automatic maybe_pause_sender();
        if (idling_on && $urandom_range(0, 3) == 0) begin
            @(negedge clk);
            req_valid <= 1'b0;
            repeat ($urandom_range(0, 7)) @(negedge clk);
        end
    endtask

    // Stop sending until every expected result item has come back.
    task automatic hold_until_drained();
        @(negedge clk);
        req_valid <= 1'b0;
        while (pending_count != 0) @(negedge clk);
    endtask

    // One random request, mostly small delays and recent identifiers.
    task automatic send_random_request();
        int                        pick;
        int                        shape;
        int                        lo;
        tmr_pkg::t_action          act;
        logic [tmr_pkg::AMT_W-1:0] amount;
        logic [tmr_pkg::ID_W-1:0]  ident;
        pick   = $urandom_range(0, 99);
        shape  = $urandom_range(0, 19);
        amount = $urandom;
        ident  = $urandom;
        if (pick < 20) act = tmr_pkg::ACT_REG_PER;
        else if (pick < 38) act = tmr_pkg::ACT_REG_ONE;
        else if (pick < 58) act = tmr_pkg::ACT_CANCEL;
        else act = tmr_pkg::ACT_TICK;
        if (act == tmr_pkg::ACT_CANCEL) begin
            lo = (ids_handed_out > NUM_TIMERS) ? ids_handed_out - NUM_TIMERS : 1;
            if (shape == 0) ident = '0;
            else if (shape > 1) ident = $urandom_range(lo, ids_handed_out + 1);
        end else begin
            if (shape == 0) amount = '0;
            else if (shape == 1) amount = '1;
            else if (shape > 2) amount = (act == tmr_pkg::ACT_TICK) ? $urandom_range(1, 12)
                                                                    : $urandom_range(1, 24);
        end
        send_request(act, amount, ident);
    endtask

    // Directed checks, then random traffic, then a quiet tail and the verdict.
    initial begin
        rst_n          = 1'b0;
        req_valid      = 1'b0;
        req_action     = tmr_pkg::ACT_TICK;
        req_amount_ms  = '0;
        req_timer_id   = '0;
        idling_on      = 1'b1;
        ids_handed_out = 0;
        for (int a = 0; a < 4; a++) begin
            action_count[a] = 0;
        end
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;

        // Zero delay, the smallest and largest delays, a tick of zero and an overshoot.
        send_request(tmr_pkg::ACT_REG_PER, '0, '0);
        send_request(tmr_pkg::ACT_REG_PER, 32'd1, '1);
        send_request(tmr_pkg::ACT_REG_ONE, '1, '0);
        maybe_pause_sender();
        send_request(tmr_pkg::ACT_REG_ONE, 32'd2, '0);
        send_request(tmr_pkg::ACT_TICK, '0, '0);
        send_request(tmr_pkg::ACT_TICK, '1, '0);
        // Cancel of an unknown identifier, then of the one periodic timer left.
        send_request(tmr_pkg::ACT_CANCEL, '0, '1);
        send_request(tmr_pkg::ACT_CANCEL, '0, 32'd1);
        // Fill every slot, overflow the table, then expire half of it.
        for (int s = 0; s < NUM_TIMERS; s++) begin
            send_request((s % 2) ? tmr_pkg::ACT_REG_ONE : tmr_pkg::ACT_REG_PER, s + 1, '0);
            maybe_pause_sender();
        end
        send_request(tmr_pkg::ACT_REG_PER, 32'd7, '0);
        send_request(tmr_pkg::ACT_TICK, 32'd8, '0);
        hold_until_drained();

        // Random traffic; the last stretch runs with no idling at all.
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n >= RANDOM_ITEMS - QUIET_ITEMS) idling_on = 1'b0;
            else if (n % 40 == 0) idling_on = ($urandom_range(0, 3) != 0);
            send_random_request();
            maybe_pause_sender();
        end
        hold_until_drained();
        repeat (40) @(negedge clk);

        $display("Requests sent: %0d periodic, %0d one-shot, %0d cancel, %0d tick.",
                 action_count[tmr_pkg::ACT_REG_PER], action_count[tmr_pkg::ACT_REG_ONE],
                 action_count[tmr_pkg::ACT_CANCEL], action_count[tmr_pkg::ACT_TICK]);
        $display("Result items checked: %0d, of which %0d timer expiries; %0d failures.",
                 result_count, fire_count, fail_count);
        if (fail_count == 0 && pending_count == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #5_000_000;
        $display("tb_top failed");
        $finish;
    end

endmodule
